/* design/trpd_pkg.sv */
package trpd_pkg;

    localparam int PALETTE_BANKS = 4;
    localparam int MAX_RUN       = 32;

    localparam int PAL_DEPTH = PALETTE_BANKS * 256;
    localparam int PAL_AW    = $clog2(PAL_DEPTH);

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int IN_DATA_W  = 40;
    localparam int OUT_DATA_W = 88;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PALETTE_MODE = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PALETTE_BANK = 2'd3;

    // input commands
    localparam logic CMD_DECODE  = 1'b0;
    localparam logic CMD_PALETTE = 1'b1;

    // token types
    localparam logic [2:0] TK_LITERAL = 3'h0;
    localparam logic [2:0] TK_SKIP    = 3'h1;
    localparam logic [2:0] TK_REPEAT  = 3'h2;
    localparam logic [2:0] TK_LINE    = 3'h4;

    // result status
    localparam logic [1:0] ST_IN_FRAME  = 2'd0;
    localparam logic [1:0] ST_OUT_FRAME = 2'd1;
    localparam logic [1:0] ST_ERROR     = 2'd2;

    typedef struct packed {
        logic [15:0] image_width;
        logic [15:0] image_height;
        logic        palette_mode;
        logic [1:0]  palette_bank;
    } cfg_t;

    typedef struct packed {
        logic [7:0]  blue;
        logic [7:0]  green;
        logic [7:0]  red;
        logic [31:0] linear_address;
        logic [15:0] row;
        logic [15:0] column;
        logic [1:0]  status;
        logic        run_last;
    } out_item_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_EMIT
    } dec_state_t;

    typedef enum logic [1:0] {
        ACT_NONE,
        ACT_READ,
        ACT_EMIT,
        ACT_ERROR
    } dec_act_t;

    // bank number folded into the implemented banks
    function automatic logic [1:0] bank_wrap(input logic [1:0] bank);
        logic [8:0] v;
        v = {7'd0, bank};
        for (int i = 0; i < 3; i++)
        begin
            if (v >= 9'(PALETTE_BANKS))
            begin
                v = v - 9'(PALETTE_BANKS);
            end
        end
        return v[1:0];
    endfunction

endpackage

/* design/trpd_ram.sv */
module trpd_ram #(
    parameter int WIDTH = 15,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* design/trpd_decoder.sv */
module trpd_decoder (
    input  logic                             clk,
    input  logic                             rst_n,
    input  trpd_pkg::cfg_t                   cfg,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // stream_byte, entry_address, entry_colour, zero pad
    input  logic [trpd_pkg::IN_DATA_W-1:0]   s_tdata,
    // cmd, stream_start
    input  logic [1:0]                       s_tuser,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // column, row, linear_address, red, green, blue
    output logic [trpd_pkg::OUT_DATA_W-1:0]  m_tdata,
    // status
    output logic [1:0]                       m_tuser,
    output logic                             m_tlast
);

    trpd_pkg::dec_state_t state_reg, state_next;
    trpd_pkg::dec_act_t   act;

    logic [15:0] col_reg, col_next;
    logic [15:0] row_reg, row_next;
    logic [31:0] row_base_reg, row_base_next;
    logic [5:0]  left_reg, left_next;
    logic        rep_reg, rep_next;
    logic [7:0]  low_reg, low_next;
    logic        phase_reg, phase_next;
    logic        err_reg, err_next;
    logic        pend_err_reg, pend_err_next;
    logic [14:0] colour_reg, colour_next;

    logic                 out_valid_reg, out_valid_next;
    trpd_pkg::out_item_t  out_item_reg, out_item_next;

    logic        accept, dec_accept, s_cmd, s_start;
    logic [7:0]  s_byte;
    logic [9:0]  s_entry_addr;
    logic [14:0] s_entry_colour;
    logic [15:0] e_col, e_row;
    logic [5:0]  e_left, tok_len;
    logic        e_rep, e_phase, e_err;
    logic [7:0]  e_low;
    logic        out_free, out_load, last_beat;

    logic                        ram_we, ram_re;
    logic [16:0]                 wr_full, rd_full;
    logic [trpd_pkg::PAL_AW-1:0] ram_waddr, ram_raddr;
    logic [14:0]                 ram_rdata;

    assign s_cmd          = s_tuser[0];
    assign s_start        = s_tuser[1];
    assign s_byte         = s_tdata[7:0];
    assign s_entry_addr   = s_tdata[17:8];
    assign s_entry_colour = s_tdata[32:18];

    assign s_tready   = (state_reg == trpd_pkg::S_IDLE);
    assign accept     = s_tvalid && s_tready;
    assign dec_accept = accept && (s_cmd == trpd_pkg::CMD_DECODE);

    assign out_free  = !out_valid_reg || m_tready;
    assign last_beat = pend_err_reg || !rep_reg || (left_reg == 6'd1);
    assign out_load  = (state_reg == trpd_pkg::S_EMIT) && out_free;

    // stream start resets the position and run state before the byte is decoded
    assign e_col   = s_start ? 16'd0 : col_reg;
    assign e_row   = s_start ? (cfg.image_height - 16'd1) : row_reg;
    assign e_left  = s_start ? 6'd0 : left_reg;
    assign e_rep   = s_start ? 1'b0 : rep_reg;
    assign e_phase = s_start ? 1'b0 : phase_reg;
    assign e_err   = s_start ? 1'b0 : err_reg;
    assign e_low   = s_start ? 8'd0 : low_reg;
    assign tok_len = {1'b0, s_byte[4:0]} + 6'd1;

    // palette store
    assign wr_full   = 17'(s_entry_addr);
    assign ram_waddr = wr_full[trpd_pkg::PAL_AW-1:0];
    assign ram_we    = accept && (s_cmd == trpd_pkg::CMD_PALETTE)
                       && (wr_full < 17'(trpd_pkg::PAL_DEPTH));
    assign rd_full   = {7'd0, trpd_pkg::bank_wrap(cfg.palette_bank), s_byte};
    assign ram_raddr = rd_full[trpd_pkg::PAL_AW-1:0];
    assign ram_re    = dec_accept && (act == trpd_pkg::ACT_READ);

    trpd_ram #(
        .WIDTH(15),
        .DEPTH(trpd_pkg::PAL_DEPTH)
    ) u_palette (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(s_entry_colour),
        .re   (ram_re),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    // classify the item at the input
    always_comb
    begin
        act = trpd_pkg::ACT_NONE;
        if (s_cmd == trpd_pkg::CMD_DECODE)
        begin
            priority if (e_err)
            begin
                act = trpd_pkg::ACT_ERROR;
            end
            else if (e_left == 6'd0)
            begin
                unique case (s_byte[7:5])
                    trpd_pkg::TK_LITERAL,
                    trpd_pkg::TK_REPEAT,
                    trpd_pkg::TK_SKIP,
                    trpd_pkg::TK_LINE: act = trpd_pkg::ACT_NONE;
                    default:           act = trpd_pkg::ACT_ERROR;
                endcase
            end
            else if (cfg.palette_mode)
            begin
                act = trpd_pkg::ACT_READ;
            end
            else if (e_phase)
            begin
                act = trpd_pkg::ACT_EMIT;
            end
            else
            begin
                act = trpd_pkg::ACT_NONE;
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            trpd_pkg::S_IDLE:
            begin
                if (dec_accept)
                begin
                    unique case (act)
                        trpd_pkg::ACT_READ:  state_next = trpd_pkg::S_READ;
                        trpd_pkg::ACT_EMIT,
                        trpd_pkg::ACT_ERROR: state_next = trpd_pkg::S_EMIT;
                        default:             state_next = trpd_pkg::S_IDLE;
                    endcase
                end
            end
            trpd_pkg::S_READ:
            begin
                state_next = trpd_pkg::S_EMIT;
            end
            trpd_pkg::S_EMIT:
            begin
                if (out_free && last_beat)
                begin
                    state_next = trpd_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = trpd_pkg::S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        col_next      = col_reg;
        row_next      = row_reg;
        left_next     = left_reg;
        rep_next      = rep_reg;
        low_next      = low_reg;
        phase_next    = phase_reg;
        err_next      = err_reg;
        pend_err_next = pend_err_reg;
        colour_next   = colour_reg;

        if (dec_accept)
        begin
            col_next      = e_col;
            row_next      = e_row;
            left_next     = e_left;
            rep_next      = e_rep;
            low_next      = e_low;
            phase_next    = e_phase;
            err_next      = e_err;
            pend_err_next = (act == trpd_pkg::ACT_ERROR);
            if (!e_err)
            begin
                priority if (e_left == 6'd0)
                begin
                    unique case (s_byte[7:5])
                        trpd_pkg::TK_LITERAL:
                        begin
                            rep_next   = 1'b0;
                            left_next  = tok_len;
                            phase_next = 1'b0;
                        end
                        trpd_pkg::TK_REPEAT:
                        begin
                            rep_next   = 1'b1;
                            left_next  = tok_len;
                            phase_next = 1'b0;
                        end
                        trpd_pkg::TK_SKIP:
                        begin
                            col_next = e_col + 16'(tok_len);
                        end
                        trpd_pkg::TK_LINE:
                        begin
                            col_next = 16'd0;
                            if (e_row != 16'd0)
                            begin
                                row_next = e_row - 16'd1;
                            end
                        end
                        default:
                        begin
                            err_next = 1'b1;
                        end
                    endcase
                end
                else if (cfg.palette_mode)
                begin
                    phase_next = 1'b0;
                end
                else if (!e_phase)
                begin
                    low_next   = s_byte;
                    phase_next = 1'b1;
                end
                else
                begin
                    colour_next = {s_byte[6:0], e_low};
                    phase_next  = 1'b0;
                end
            end
        end

        if (state_reg == trpd_pkg::S_READ)
        begin
            colour_next = ram_rdata;
        end

        if (out_load && !pend_err_reg)
        begin
            col_next  = col_reg + 16'd1;
            left_next = left_reg - 6'd1;
        end
    end

    // row base is registered alongside the row; no pixel leaves in the accept cycle
    assign row_base_next = 32'(row_next) * 32'(cfg.image_width);

    always_comb
    begin
        out_item_next = out_item_reg;
        if (out_load)
        begin
            if (pend_err_reg)
            begin
                out_item_next = '0;
                out_item_next.status   = trpd_pkg::ST_ERROR;
                out_item_next.run_last = 1'b1;
            end
            else
            begin
                out_item_next.status = (col_reg >= cfg.image_width) ?
                                       trpd_pkg::ST_OUT_FRAME : trpd_pkg::ST_IN_FRAME;
                out_item_next.column         = col_reg;
                out_item_next.row            = row_reg;
                out_item_next.linear_address = row_base_reg + 32'(col_reg);
                out_item_next.red            = {colour_reg[14:10], 3'b000};
                out_item_next.green          = {colour_reg[9:5], 3'b000};
                out_item_next.blue           = {colour_reg[4:0], 3'b000};
                out_item_next.run_last       = last_beat;
            end
        end
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= trpd_pkg::S_IDLE;
            col_reg       <= 16'd0;
            row_reg       <= 16'd0;
            left_reg      <= 6'd0;
            rep_reg       <= 1'b0;
            low_reg       <= 8'd0;
            phase_reg     <= 1'b0;
            err_reg       <= 1'b0;
            pend_err_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            col_reg       <= col_next;
            row_reg       <= row_next;
            left_reg      <= left_next;
            rep_reg       <= rep_next;
            low_reg       <= low_next;
            phase_reg     <= phase_next;
            err_reg       <= err_next;
            pend_err_reg  <= pend_err_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        colour_reg   <= colour_next;
        row_base_reg <= row_base_next;
        out_item_reg <= out_item_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_item_reg.status;
    assign m_tlast  = out_item_reg.run_last;
    assign m_tdata  = {out_item_reg.blue, out_item_reg.green, out_item_reg.red,
                       out_item_reg.linear_address, out_item_reg.row,
                       out_item_reg.column};

    // error results are always single
    a_error_single : assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tuser == trpd_pkg::ST_ERROR)) |-> m_tlast)
        else $error("error result without last flag");

    // palette data is captured right after the read
    a_read_then_emit : assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == trpd_pkg::S_READ) |=> (state_reg == trpd_pkg::S_EMIT))
        else $error("palette read not followed by emission");

    // a pixel run never emits past its length
    a_run_nonempty : assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == trpd_pkg::S_EMIT) && !pend_err_reg) |-> (left_reg != 6'd0))
        else $error("pixel emitted with empty run");

endmodule

/* design/token_rle_pixel_decoder_core.sv */
// Token run-length image decoder. Each input item is either a palette write
// (cmd 1) or one stream byte (cmd 0); stream_start on a byte restarts at column 0
// of the top row and clears a sticky error. Palette writes, token bytes and the
// first byte of a direct colour word give no result and leave the input ready. A
// byte that completes a colour is accepted, its colour is read from the palette
// memory in palette mode, then it is emitted as pixels (1 for a literal, up to 32
// for a repeat run), one per cycle while m_tready allows, through the single
// output register; the input stalls until the last pixel of the item is loaded.
// Unknown tokens give one result with status 2. The palette memory has no reset:
// entries must be written before use. Configuration must be written through
// cfg_we/cfg_index/cfg_data while the block is idle; the block does not enforce this.
module token_rle_pixel_decoder_core (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [trpd_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [trpd_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // stream_byte, entry_address, entry_colour, zero pad
    input  logic [trpd_pkg::IN_DATA_W-1:0]     s_tdata,
    // cmd, stream_start
    input  logic [1:0]                         s_tuser,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // column, row, linear_address, red, green, blue
    output logic [trpd_pkg::OUT_DATA_W-1:0]    m_tdata,
    // status
    output logic [1:0]                         m_tuser,
    output logic                               m_tlast
);

    trpd_pkg::cfg_t cfg_reg, cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                trpd_pkg::CFG_IMAGE_WIDTH:  cfg_next.image_width  = cfg_data;
                trpd_pkg::CFG_IMAGE_HEIGHT: cfg_next.image_height = cfg_data;
                trpd_pkg::CFG_PALETTE_MODE: cfg_next.palette_mode = cfg_data[0];
                trpd_pkg::CFG_PALETTE_BANK: cfg_next.palette_bank = cfg_data[1:0];
                default:                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    trpd_decoder u_decoder (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_reg),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser),
        .m_tlast (m_tlast)
    );

endmodule
